>>> design/uqe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uqe_pkg;

    localparam int QUEUE_DEPTH_DEF = 140;
    localparam int BURST_LEN_DEF   = 14;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_TX   = 2'd2;
    localparam logic [1:0] KIND_RX   = 2'd3;

    typedef enum logic [1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_TXE  = 2'd2,
        FN_RX   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND_RD,
        ST_SEND_OUT,
        ST_RECV_RD,
        ST_RECV_OUT
    } back_state_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_in;
        logic       tx_ready;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] data_out;
        logic       ok;
        logic       dropped_oldest;
        logic       last;
    } out_item_t;

    // Classified command handed from front to back
    typedef struct packed {
        func_t      op;
        logic [7:0] data;
        logic       drain_req;
    } cmd_t;

    function automatic out_item_t make_res(logic [1:0] kind, logic [7:0] data,
                                           logic ok, logic dropped, logic last);
        out_item_t r;
        r.result_kind    = kind;
        r.data_out       = data;
        r.ok             = ok;
        r.dropped_oldest = dropped;
        r.last           = last;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/uqe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module uqe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 140
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/uqe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module uqe_front
    import uqe_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_payload,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    localparam int Q_SLOTS = 2;

    cmd_t       q_reg [Q_SLOTS];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       push, pop;

    always_comb begin
        cls.op        = func_t'(s_payload.func);
        cls.data      = s_payload.data_in;
        cls.drain_req = (s_payload.func == FN_TXE) ||
                        ((s_payload.func == FN_PUSH) && s_payload.tx_ready);
    end

    assign s_ready   = (cnt_reg != 2'(Q_SLOTS));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(Q_SLOTS))
        else $error("front queue overfilled");

    a_cnt_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("front queue lost a transaction");

endmodule

`default_nettype wire

>>> design/uqe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module uqe_back
    import uqe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BURST_LEN   = BURST_LEN_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_payload
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(BURST_LEN + 1);

    back_state_t      state_reg, state_next;
    logic [PTR_W-1:0] send_head_reg, send_head_next;
    logic [PTR_W-1:0] send_tail_reg, send_tail_next;
    logic [PTR_W-1:0] recv_head_reg, recv_head_next;
    logic [PTR_W-1:0] recv_tail_reg, recv_tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             enabled_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             send_we, recv_we;
    logic [7:0]       send_rdata, recv_rdata;
    logic             out_free, go, drop, blast;
    logic [PTR_W-1:0] rx_tail_n;

    function automatic logic [PTR_W-1:0] wrap_next(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    uqe_ram #(.DATA_W(8), .DEPTH(QUEUE_DEPTH)) u_send_ram (
        .aclk  (aclk),
        .we    (send_we),
        .waddr (send_tail_reg),
        .wdata (cmd.data),
        .raddr (send_head_reg),
        .rdata (send_rdata)
    );

    uqe_ram #(.DATA_W(8), .DEPTH(QUEUE_DEPTH)) u_recv_ram (
        .aclk  (aclk),
        .we    (recv_we),
        .waddr (recv_tail_reg),
        .wdata (cmd.data),
        .raddr (recv_head_reg),
        .rdata (recv_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        send_head_next = send_head_reg;
        send_tail_next = send_tail_reg;
        recv_head_next = recv_head_reg;
        recv_tail_next = recv_tail_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        cmd_ready      = 1'b0;
        send_we        = 1'b0;
        recv_we        = 1'b0;
        go             = 1'b0;
        drop           = 1'b0;
        blast          = 1'b0;
        rx_tail_n      = wrap_next(recv_tail_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    unique case (cmd.op)
                        FN_PUSH: begin
                            if (wrap_next(send_tail_reg) == send_head_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next  = make_res(KIND_PUSH, 8'd0, 1'b0, 1'b0, 1'b1);
                            end else begin
                                send_we        = 1'b1;
                                send_tail_next = wrap_next(send_tail_reg);
                                go             = enabled_reg && cmd.drain_req;
                                m_valid_next   = 1'b1;
                                m_data_next    = make_res(KIND_PUSH, 8'd0, 1'b1, 1'b0, !go);
                                if (go) begin
                                    cnt_next   = '0;
                                    state_next = ST_SEND_RD;
                                end
                            end
                        end
                        FN_POP: begin
                            if (recv_head_reg == recv_tail_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next  = make_res(KIND_POP, 8'd0, 1'b0, 1'b0, 1'b1);
                            end else begin
                                state_next = ST_RECV_RD;
                            end
                        end
                        FN_TXE: begin
                            if (enabled_reg && cmd.drain_req &&
                                (send_head_reg != send_tail_reg)) begin
                                cnt_next   = '0;
                                state_next = ST_SEND_RD;
                            end
                        end
                        FN_RX: begin
                            m_valid_next = 1'b1;
                            if (enabled_reg) begin
                                recv_we        = 1'b1;
                                recv_tail_next = rx_tail_n;
                                drop           = (rx_tail_n == recv_head_reg);
                                if (drop) begin
                                    recv_head_next = wrap_next(recv_head_reg);
                                end
                                m_data_next = make_res(KIND_RX, 8'd0, 1'b1, drop, 1'b1);
                            end else begin
                                m_data_next = make_res(KIND_RX, 8'd0, 1'b0, 1'b0, 1'b1);
                            end
                        end
                    endcase
                end
            end
            ST_SEND_RD: begin
                state_next = ST_SEND_OUT;
            end
            ST_SEND_OUT: begin
                if (out_free) begin
                    blast          = (cnt_reg == CNT_W'(BURST_LEN - 1)) ||
                                     (wrap_next(send_head_reg) == send_tail_reg);
                    m_valid_next   = 1'b1;
                    m_data_next    = make_res(KIND_TX, send_rdata, 1'b1, 1'b0, blast);
                    send_head_next = wrap_next(send_head_reg);
                    cnt_next       = cnt_reg + CNT_W'(1);
                    state_next     = blast ? ST_IDLE : ST_SEND_RD;
                end
            end
            ST_RECV_RD: begin
                state_next = ST_RECV_OUT;
            end
            ST_RECV_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = make_res(KIND_POP, recv_rdata, 1'b1, 1'b0, 1'b1);
                    recv_head_next = wrap_next(recv_head_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            send_head_reg <= '0;
            send_tail_reg <= '0;
            recv_head_reg <= '0;
            recv_tail_reg <= '0;
            cnt_reg       <= '0;
            enabled_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            send_head_reg <= send_head_next;
            send_tail_reg <= send_tail_next;
            recv_head_reg <= recv_head_next;
            recv_tail_reg <= recv_tail_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                enabled_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        send_head_reg <= PTR_W'(QUEUE_DEPTH - 1) && send_tail_reg <= PTR_W'(QUEUE_DEPTH - 1) &&
        recv_head_reg <= PTR_W'(QUEUE_DEPTH - 1) && recv_tail_reg <= PTR_W'(QUEUE_DEPTH - 1))
        else $error("ring pointer out of range");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND_RD || state_reg == ST_SEND_OUT) |->
        send_head_reg != send_tail_reg)
        else $error("drain from empty send ring");

    a_burst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND_OUT) |-> cnt_reg < CNT_W'(BURST_LEN))
        else $error("drain burst overran");

    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RECV_OUT && out_free) |=>
        m_valid_reg && m_data_reg.last && m_data_reg.ok)
        else $error("pop result malformed");

endmodule

`default_nettype wire

>>> design/uart_buffered_queue_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Send and receive ring buffers of one serial port, QUEUE_DEPTH slots each (holding
// QUEUE_DEPTH-1 bytes). Transactions enter a two-entry command queue and are carried out
// one at a time by the back end: a push, a receive or a pop of an empty ring is handled in
// the idle state; a pop with data passes a RAM read state and an output state, and so does
// every byte of a drain burst (up to BURST_LEN), since the ring RAM read is registered. A
// result waits in the output register while the front keeps accepting until its queue is
// full. Writing port_enabled is allowed only while idle. No clearing pass runs after reset.
module uart_buffered_queue_engine
    import uqe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BURST_LEN   = BURST_LEN_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_payload,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_payload
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    uqe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    uqe_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BURST_LEN   (BURST_LEN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire
